### rtl/core/cle_pkg.sv
package cle_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int PTR_SPAN  = 2 * BUF_DEPTH;
  localparam int PTR_W     = $clog2(PTR_SPAN);
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int BYTE_W    = 8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t KEY_NUL    = 8'h00;
  localparam byte_t KEY_CTRL_D = 8'h04;
  localparam byte_t KEY_CTRL_H = 8'h08;
  localparam byte_t KEY_LF     = 8'h0A;
  localparam byte_t KEY_CR     = 8'h0D;
  localparam byte_t KEY_CTRL_P = 8'h10;
  localparam byte_t KEY_CTRL_S = 8'h13;
  localparam byte_t KEY_CTRL_U = 8'h15;
  localparam byte_t KEY_ESC    = 8'h1B;
  localparam byte_t KEY_DEL    = 8'h7F;
  localparam byte_t ERASE_MAX  = 8'hFF;

  typedef enum logic {
    OP_KEY,
    OP_READ
  } opcode_e;

  typedef enum logic [1:0] {
    ECHO_NONE,
    ECHO_CHAR,
    ECHO_ERASE
  } echo_kind_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_BYTE,
    RD_EMPTY,
    RD_EOF_USED,
    RD_EOF_KEPT
  } read_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_KILL_WAIT,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    echo_kind_e   echo_kind;
    byte_t        echo_char;
    byte_t        erase_count;
    logic         line_committed;
    logic         dump_request;
    byte_t        read_byte;
    read_status_e read_status;
    logic         read_ends;
  } result_t;

  localparam result_t RESULT_IDLE = '{
    echo_kind:      ECHO_NONE,
    echo_char:      KEY_NUL,
    erase_count:    KEY_NUL,
    line_committed: 1'b0,
    dump_request:   1'b0,
    read_byte:      KEY_NUL,
    read_status:    RD_NONE,
    read_ends:      1'b0
  };

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec_key;
    logic read_empty;
    logic read_issue;
    logic read_finish;
    logic kill_issue;
    logic kill_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic is_kill;
    logic rd_empty;
    logic kill_empty;
    logic kill_lf;
    logic kill_last;
    logic out_free;
  } sts_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(PTR_SPAN - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? ptr_t'(PTR_SPAN - 1) : ptr_t'(p - ptr_t'(1));
  endfunction

  function automatic addr_t ptr_addr(input ptr_t p);
    return (p >= ptr_t'(BUF_DEPTH)) ? addr_t'(p - ptr_t'(BUF_DEPTH)) : addr_t'(p);
  endfunction

  function automatic ptr_t ptr_dist(input ptr_t hi, input ptr_t lo);
    logic [PTR_W:0] wrapped;
    wrapped = {1'b0, hi} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, lo};
    return (hi >= lo) ? ptr_t'(hi - lo) : ptr_t'(wrapped);
  endfunction

  function automatic byte_t erase_sat(input cnt_t n);
    return (int'(n) > int'(ERASE_MAX)) ? ERASE_MAX : byte_t'(n);
  endfunction

endpackage

### rtl/core/cle_if.sv
interface cle_in_if import cle_pkg::*;;
  logic  valid;
  logic  ready;
  logic  opcode;
  byte_t key_byte;
  logic  request_has_bytes;

  modport source (output valid, opcode, key_byte, request_has_bytes, input ready);
  modport sink   (input valid, opcode, key_byte, request_has_bytes, output ready);
endinterface

interface cle_out_if import cle_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] echo_kind;
  byte_t      echo_char;
  byte_t      erase_count;
  logic       line_committed;
  logic       dump_request;
  byte_t      read_byte;
  logic [2:0] read_status;
  logic       read_ends;

  modport source (output valid, echo_kind, echo_char, erase_count, line_committed,
                  dump_request, read_byte, read_status, read_ends, input ready);
  modport sink   (input valid, echo_kind, echo_char, erase_count, line_committed,
                  dump_request, read_byte, read_status, read_ends, output ready);
endinterface

### rtl/core/console_line_editor.sv
// Canonical line editor over a BUF_DEPTH-byte ring (read, commit and edit
// pointers). Each transfer on in_i is either a keyboard byte (opcode 0) or a
// reader request for one byte (opcode 1) and yields exactly one transfer on
// out_o. One item is worked at a time. A keyboard byte is worked in the
// execute state, where its result is registered, and is then loaded into the
// output register in the output state; the next item can be taken after the
// return to idle. A read request passes through a wait state as well, for the
// registered read port of the line store. Ctrl-U walks back through the
// store one byte per cycle and stops at a newline or at the commit point.
// A new item is taken while the previous result still waits on out_o. A
// finished result that finds out_o still occupied holds the input off until
// that transfer is done. The store needs no clearing after reset.
module console_line_editor import cle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  cle_in_if.sink   in_i,
  cle_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  cle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (in_i.opcode),
    .key_byte_i  (in_i.key_byte),
    .has_bytes_i (in_i.request_has_bytes),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule

### rtl/core/cle_ram.sv
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cle_ctrl.sv
module cle_ctrl import cle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_read) begin
          if (sts_i.rd_empty) begin
            cmd_o.read_empty = 1'b1;
            state_d          = S_OUT;
          end else begin
            cmd_o.read_issue = 1'b1;
            state_d          = S_RD_WAIT;
          end
        end else if (sts_i.is_kill) begin
          if (sts_i.kill_empty) begin
            state_d = S_OUT;
          end else begin
            cmd_o.kill_issue = 1'b1;
            state_d          = S_KILL_WAIT;
          end
        end else begin
          cmd_o.exec_key = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_RD_WAIT: begin
        cmd_o.read_finish = 1'b1;
        state_d           = S_OUT;
      end
      S_KILL_WAIT: begin
        // one stored byte checked per cycle; stop at a newline or the commit point
        if (sts_i.kill_lf) begin
          state_d = S_OUT;
        end else begin
          cmd_o.kill_step = 1'b1;
          if (sts_i.kill_last) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.kill_step |-> state_q == S_KILL_WAIT && !sts_i.kill_lf)
    else $error("kill step taken on a newline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> state_q == S_EXEC)
    else $error("accepted item not executed next cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read_issue |=> cmd_o.read_finish)
    else $error("read issue not followed by finish");

endmodule

### rtl/core/cle_dp.sv
module cle_dp import cle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          opcode_i,
  input  byte_t         key_byte_i,
  input  logic          has_bytes_i,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  cle_out_if.source     out_o
);

  logic    op_q, had_q;
  byte_t   key_q;
  ptr_t    read_q, read_d;
  ptr_t    commit_q, commit_d;
  ptr_t    edit_q, edit_d;
  cnt_t    cnt_q, cnt_d;
  result_t res_q, res_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;

  logic    ram_we, ram_re;
  addr_t   ram_raddr;
  byte_t   ram_rdata;

  byte_t   key_ch;
  ptr_t    edit_dec, edit_inc, dist_er;
  logic    has_room, fills_ring, is_kill;

  assign key_ch     = (key_q == KEY_CR) ? KEY_LF : key_q;
  assign edit_dec   = ptr_dec(edit_q);
  assign edit_inc   = ptr_inc(edit_q);
  assign dist_er    = ptr_dist(edit_q, read_q);
  assign has_room   = dist_er < ptr_t'(BUF_DEPTH);
  assign fills_ring = dist_er == ptr_t'(BUF_DEPTH - 1);
  assign is_kill    = (op_q == OP_KEY) && (key_q == KEY_CTRL_U);

  cle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_addr(edit_q)),
    .wdata_i (key_ch),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sts_o.is_read    = op_q == OP_READ;
    sts_o.is_kill    = is_kill;
    sts_o.rd_empty   = read_q == commit_q;
    sts_o.kill_empty = edit_q == commit_q;
    sts_o.kill_lf    = ram_rdata == KEY_LF;
    sts_o.kill_last  = edit_dec == commit_q;
    sts_o.out_free   = !out_valid_q || out_o.ready;
  end

  always_comb begin
    read_d      = read_q;
    commit_d    = commit_q;
    edit_d      = edit_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_addr(read_q);

    if (cmd_i.load_item) begin
      res_d = RESULT_IDLE;
      cnt_d = '0;
    end

    if (cmd_i.exec_key) begin
      if (key_q == KEY_CTRL_P) begin
        res_d.dump_request = 1'b1;
      end else if (key_q inside {KEY_CTRL_H, KEY_DEL}) begin
        if (edit_q != commit_q) begin
          edit_d            = edit_dec;
          res_d.echo_kind   = ECHO_ERASE;
          res_d.erase_count = byte_t'(1);
        end
      end else if (key_q inside {KEY_ESC, KEY_CTRL_S}) begin
        // dropped
      end else if (key_q != KEY_NUL && has_room) begin
        ram_we          = 1'b1;
        edit_d          = edit_inc;
        res_d.echo_kind = ECHO_CHAR;
        res_d.echo_char = key_ch;
        if (key_ch == KEY_LF || key_ch == KEY_CTRL_D || fills_ring) begin
          commit_d             = edit_inc;
          res_d.line_committed = 1'b1;
        end
      end
    end

    if (cmd_i.read_empty) begin
      res_d.read_status = RD_EMPTY;
    end

    if (cmd_i.read_issue) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_addr(read_q);
    end

    if (cmd_i.read_finish) begin
      if (ram_rdata == KEY_CTRL_D) begin
        // end of file stays put when the reader already has bytes
        if (had_q) begin
          res_d.read_status = RD_EOF_KEPT;
        end else begin
          read_d            = ptr_inc(read_q);
          res_d.read_status = RD_EOF_USED;
        end
      end else begin
        read_d            = ptr_inc(read_q);
        res_d.read_status = RD_BYTE;
        res_d.read_byte   = ram_rdata;
        res_d.read_ends   = ram_rdata == KEY_LF;
      end
    end

    if (cmd_i.kill_issue) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_addr(edit_dec);
    end

    if (cmd_i.kill_step) begin
      edit_d    = edit_dec;
      cnt_d     = cnt_t'(cnt_q + cnt_t'(1));
      ram_re    = 1'b1;
      ram_raddr = ptr_addr(ptr_dec(edit_dec));
    end

    if (cmd_i.out_load) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      if (is_kill) begin
        out_d.echo_kind   = (cnt_q != '0) ? ECHO_ERASE : ECHO_NONE;
        out_d.erase_count = erase_sat(cnt_q);
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q      <= '0;
      commit_q    <= '0;
      edit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      read_q      <= read_d;
      commit_q    <= commit_d;
      edit_q      <= edit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= opcode_i;
      key_q <= key_byte_i;
      had_q <= has_bytes_i;
    end
    cnt_q <= cnt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.echo_kind      = out_q.echo_kind;
  assign out_o.echo_char      = out_q.echo_char;
  assign out_o.erase_count    = out_q.erase_count;
  assign out_o.line_committed = out_q.line_committed;
  assign out_o.dump_request   = out_q.dump_request;
  assign out_o.read_byte      = out_q.read_byte;
  assign out_o.read_status    = out_q.read_status;
  assign out_o.read_ends      = out_q.read_ends;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.kill_step |-> edit_q != commit_q)
    else $error("erase stepped past the commit point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_dist(commit_q, read_q) <= ptr_dist(edit_q, read_q))
    else $error("commit pointer outside read..edit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_dist(edit_q, read_q) <= ptr_t'(BUF_DEPTH))
    else $error("ring holds more than its depth");

endmodule
